### design/breath_envelope_generator_top_macros.svh
// Assertion helpers for the breath envelope generator.
`ifndef BREATH_ENVELOPE_GENERATOR_TOP_MACROS_SVH
`define BREATH_ENVELOPE_GENERATOR_TOP_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is held.
`define BEG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define BEG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### design/beg_pkg.sv
`default_nettype none
package beg_pkg;

  localparam int unsigned EnvFracBits = 8;
  localparam int unsigned LevelW      = 12;
  localparam int unsigned EnvW        = LevelW + EnvFracBits;
  localparam int unsigned ShiftW      = 5;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 12;
  localparam int unsigned DivSteps    = 12;
  localparam int unsigned DivCntW     = 4;
  localparam int unsigned MulAW       = 16;
  localparam int unsigned MulBW       = 14;
  localparam int unsigned ProdW       = MulAW + MulBW;

  localparam logic [LevelW-1:0] LevelMax    = 12'd4095;
  localparam logic [13:0]       CurveThree  = 14'd12288;
  localparam logic [12:0]       FullScale   = 13'd4096;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegThreshold  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAtkFast    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAtkSlow    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRelMin     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRelMax     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRelTrim    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRelFloor   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegEnvFloor   = 3'd7;

  typedef enum logic [3:0] {
    StIdle,
    StKnob,
    StDiv,
    StShape1,
    StShape2,
    StShape3,
    StShape4,
    StShape5,
    StAtk,
    StAtk2,
    StTrim,
    StRel,
    StRel2,
    StEnvAtk,
    StEnvRel,
    StDone
  } state_e;

endpackage
`default_nettype wire

### design/breath_envelope_generator_top.sv
`default_nettype none
// Breath envelope generator: one input word is one control tick.
// Input stream (s_axis): main knob, CV offset, attack knob and gate level.
// Output stream (m_axis): envelope level, peak, effort and strike flag,
// exactly one output word per input word, in order.
// Configuration: write cfg_we_i with cfg_idx_i / cfg_data_i while idle;
// the register takes the value at that clock edge, no read-back.
// Datapath: one shared 16x14 signed multiplier, a one-bit-a-cycle
// restoring divider and a barrel shifter, stepped by a sequencer. A tick
// runs through up to 12 divider steps, five shaping steps, two attack
// steps and four release steps, and skips the divider and shaping steps
// when the knob is below threshold. s_axis_tready is high only while the
// sequencer is idle, so a new word is taken only after the previous tick
// is through its steps; the next word can be taken while the previous
// result still waits in the output register.
// Reset: envelope, peak, effort, gate history and output valid clear, and
// configuration registers return to their defaults.
// Stall: while m_axis_tready is low the result is held, and a finished
// tick waits in its last step until the output register frees up.
module breath_envelope_generator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [11:0] main_knob, [24:12] cv_offset, [36:25] attack_knob, [37] gate_on
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [19:0] envelope_level, [31:20] peak_level, [43:32] effort_level,
  // [44] note_struck
  output logic [47:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [beg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [beg_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned LW = beg_pkg::LevelW;
  localparam int unsigned EW = beg_pkg::EnvW;
  localparam int unsigned SW = beg_pkg::ShiftW;
  localparam int unsigned PW = beg_pkg::ProdW;

  // Configuration registers
  logic [LW-1:0] thr_q, env_floor_q;
  logic [SW-1:0] atk_fast_q, atk_slow_q, rel_min_q, rel_max_q, rel_trim_q, rel_floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= 12'd64;
      atk_fast_q  <= 5'd2;
      atk_slow_q  <= 5'd10;
      rel_min_q   <= 5'd6;
      rel_max_q   <= 5'd12;
      rel_trim_q  <= 5'd8;
      rel_floor_q <= 5'd3;
      env_floor_q <= 12'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        beg_pkg::RegThreshold: thr_q       <= cfg_data_i;
        beg_pkg::RegAtkFast:   atk_fast_q  <= cfg_data_i[SW-1:0];
        beg_pkg::RegAtkSlow:   atk_slow_q  <= cfg_data_i[SW-1:0];
        beg_pkg::RegRelMin:    rel_min_q   <= cfg_data_i[SW-1:0];
        beg_pkg::RegRelMax:    rel_max_q   <= cfg_data_i[SW-1:0];
        beg_pkg::RegRelTrim:   rel_trim_q  <= cfg_data_i[SW-1:0];
        beg_pkg::RegRelFloor:  rel_floor_q <= cfg_data_i[SW-1:0];
        beg_pkg::RegEnvFloor:  env_floor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  beg_pkg::state_e state_q, state_d;

  // Latched input word
  logic [LW-1:0] main_q, atk_knob_q;
  logic [12:0]   cv_q;
  logic          gate_q;

  // Tick state and working registers
  logic [EW-1:0] acc_q, acc_d;
  logic [LW-1:0] peak_q, peak_d, effort_q, effort_d, knob_q, knob_d;
  logic [LW-1:0] rem_q, rem_d;
  logic [beg_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] atk_shift_q, atk_shift_d, trim_q, trim_d, rel_q, rel_d;
  logic          gate_prev_q, gate_prev_d, struck_q, struck_d;
  logic signed [PW-1:0] prod_q;
  logic          out_valid_q, out_valid_d;
  logic [47:0]   out_data_q, out_data_d;

  wire in_acc  = s_axis_tvalid && s_axis_tready;
  wire out_free = !out_valid_q || m_axis_tready;

  // Knob plus CV, clamped to the 12-bit range
  logic signed [14:0] sum_s;
  logic [LW-1:0]      knob_clamp;
  logic [LW-1:0]      den, above;
  always_comb begin
    sum_s = $signed({3'b000, main_q}) + $signed({{2{cv_q[12]}}, cv_q});
    if (sum_s[14])                 knob_clamp = '0;
    else if (sum_s[13:12] != 2'b0) knob_clamp = beg_pkg::LevelMax;
    else                           knob_clamp = sum_s[LW-1:0];
    den   = beg_pkg::LevelMax - thr_q;
    above = knob_clamp - thr_q;
  end

  // Shared multiplier: operands chosen by the step in hand
  logic signed [beg_pkg::MulAW-1:0] mul_a;
  logic signed [beg_pkg::MulBW-1:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      beg_pkg::StShape1: begin
        mul_a = $signed({2'b00, beg_pkg::CurveThree - {1'b0, effort_q, 1'b0}});
        mul_b = $signed({2'b00, effort_q});
      end
      beg_pkg::StShape2: begin
        mul_a = $signed({4'b0000, effort_q});
        mul_b = $signed({1'b0, prod_q[24:12]});
      end
      beg_pkg::StShape4: begin
        mul_a = $signed({3'b000, beg_pkg::FullScale - {1'b0, peak_q}});
        mul_b = $signed({2'b00, peak_q});
      end
      beg_pkg::StAtk: begin
        mul_a = $signed({4'b0000, atk_knob_q});
        mul_b = $signed({{8{1'b0}}, 1'b0, atk_slow_q}) - $signed({{8{1'b0}}, 1'b0, atk_fast_q});
      end
      beg_pkg::StTrim: begin
        mul_a = $signed({3'b000, beg_pkg::FullScale - {1'b0, knob_q}});
        mul_b = $signed({{8{1'b0}}, 1'b0, rel_trim_q});
      end
      beg_pkg::StRel: begin
        mul_a = $signed({4'b0000, peak_q});
        mul_b = $signed({{8{1'b0}}, 1'b0, rel_max_q}) - $signed({{8{1'b0}}, 1'b0, rel_min_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Divider step
  logic [LW:0] rem_sh;
  logic        div_bit;
  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    div_bit = (rem_sh >= {1'b0, den});
  end

  // Envelope step helpers
  logic [EW-1:0] target, diff_up, diff_dn, step_up, step_dn, step_rl, rel_new;
  logic [SW:0]   rel_lim;
  logic [SW-1:0] rel_raw;
  logic [12:0]   pk_sum;
  always_comb begin
    target  = {peak_q, {beg_pkg::EnvFracBits{1'b0}}};
    diff_up = target - acc_q;
    diff_dn = acc_q - target;
    step_up = diff_up >> atk_shift_q;
    step_dn = diff_dn >> atk_shift_q;
    step_rl = acc_q >> rel_q;
    if (step_up == '0) step_up = {{(EW-1){1'b0}}, 1'b1};
    if (step_dn == '0) step_dn = {{(EW-1){1'b0}}, 1'b1};
    if (step_rl == '0) step_rl = {{(EW-1){1'b0}}, 1'b1};
    rel_new = acc_q - step_rl;
    rel_raw = rel_min_q + prod_q[16:12];
    rel_lim = {1'b0, trim_q} + {1'b0, rel_floor_q};
    pk_sum  = {1'b0, peak_q} + {1'b0, prod_q[23:12]};
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      beg_pkg::StIdle:   if (in_acc) state_d = beg_pkg::StKnob;
      beg_pkg::StKnob: begin
        if (knob_clamp < thr_q)  state_d = beg_pkg::StAtk;
        else if (above == den)   state_d = beg_pkg::StShape1;
        else                     state_d = beg_pkg::StDiv;
      end
      beg_pkg::StDiv:
        if (cnt_q == 4'(beg_pkg::DivSteps - 1)) state_d = beg_pkg::StShape1;
      beg_pkg::StShape1: state_d = beg_pkg::StShape2;
      beg_pkg::StShape2: state_d = beg_pkg::StShape3;
      beg_pkg::StShape3: state_d = beg_pkg::StShape4;
      beg_pkg::StShape4: state_d = beg_pkg::StShape5;
      beg_pkg::StShape5: state_d = beg_pkg::StAtk;
      beg_pkg::StAtk:    state_d = beg_pkg::StAtk2;
      beg_pkg::StAtk2: begin
        if (gate_q)              state_d = beg_pkg::StEnvAtk;
        else if (acc_q != '0)    state_d = beg_pkg::StTrim;
        else                     state_d = beg_pkg::StDone;
      end
      beg_pkg::StTrim:   state_d = beg_pkg::StRel;
      beg_pkg::StRel:    state_d = beg_pkg::StRel2;
      beg_pkg::StRel2:   state_d = beg_pkg::StEnvRel;
      beg_pkg::StEnvAtk: state_d = beg_pkg::StDone;
      beg_pkg::StEnvRel: state_d = beg_pkg::StDone;
      beg_pkg::StDone:   if (out_free) state_d = beg_pkg::StIdle;
      default:           state_d = beg_pkg::StIdle;
    endcase
  end

  // Datapath updates per step
  always_comb begin
    acc_d       = acc_q;
    peak_d      = peak_q;
    effort_d    = effort_q;
    knob_d      = knob_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    atk_shift_d = atk_shift_q;
    trim_d      = trim_q;
    rel_d       = rel_q;
    gate_prev_d = gate_prev_q;
    struck_d    = struck_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    case (state_q)
      beg_pkg::StKnob: begin
        knob_d = knob_clamp;
        rem_d  = above;
        cnt_d  = '0;
        if (knob_clamp < thr_q) begin
          peak_d   = '0;
          effort_d = '0;
        end else if (above == den) begin
          effort_d = beg_pkg::LevelMax;
        end
      end
      beg_pkg::StDiv: begin
        rem_d    = div_bit ? LW'(rem_sh - {1'b0, den}) : rem_sh[LW-1:0];
        effort_d = {effort_q[LW-2:0], div_bit};
        cnt_d    = cnt_q + 4'd1;
      end
      beg_pkg::StShape3: peak_d = prod_q[23:12];
      beg_pkg::StShape5: peak_d = pk_sum[12] ? beg_pkg::LevelMax : pk_sum[LW-1:0];
      beg_pkg::StAtk2: begin
        atk_shift_d = atk_fast_q + prod_q[16:12];
        struck_d    = gate_q && !gate_prev_q;
        gate_prev_d = gate_q;
      end
      beg_pkg::StRel:  trim_d = prod_q[16:12];
      beg_pkg::StRel2: rel_d  = ({1'b0, rel_raw} > rel_lim) ? rel_raw - trim_q : rel_floor_q;
      beg_pkg::StEnvAtk: begin
        if (acc_q < target)      acc_d = acc_q + step_up;
        else if (acc_q > target) acc_d = acc_q - step_dn;
      end
      beg_pkg::StEnvRel: begin
        acc_d = (rel_new < {env_floor_q, {beg_pkg::EnvFracBits{1'b0}}}) ? '0 : rel_new;
      end
      beg_pkg::StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, struck_q, effort_q, peak_q, acc_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= beg_pkg::StIdle;
      acc_q       <= '0;
      peak_q      <= '0;
      effort_q    <= '0;
      knob_q      <= '0;
      atk_shift_q <= 5'd2;
      gate_prev_q <= 1'b0;
      struck_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      peak_q      <= peak_d;
      effort_q    <= effort_d;
      knob_q      <= knob_d;
      atk_shift_q <= atk_shift_d;
      gate_prev_q <= gate_prev_d;
      struck_q    <= struck_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    trim_q     <= trim_d;
    rel_q      <= rel_d;
    out_data_q <= out_data_d;
    if (in_acc) begin
      main_q     <= s_axis_tdata[11:0];
      cv_q       <= s_axis_tdata[24:12];
      atk_knob_q <= s_axis_tdata[36:25];
      gate_q     <= s_axis_tdata[37];
    end
  end

  assign s_axis_tready = (state_q == beg_pkg::StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`include "breath_envelope_generator_top_macros.svh"

  `BEG_ASSERT_IMP(a_busy_not_ready, state_q != beg_pkg::StIdle, !s_axis_tready, "ready while busy")
  `BEG_ASSERT_IMP(a_div_count, state_q == beg_pkg::StDiv, cnt_q < 4'(beg_pkg::DivSteps), "divider overrun")
  `BEG_ASSERT(a_acc_range, acc_q <= {beg_pkg::LevelMax, {beg_pkg::EnvFracBits{1'b0}}}, "envelope above full scale")

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: models one control tick of the envelope generator and keeps
// the words it expects on the output stream.
class envelope_scoreboard;
  // configuration registers
  logic [11:0] threshold;
  logic [4:0]  atk_fast, atk_slow, rel_min, rel_max, rel_trim, rel_floor;
  logic [11:0] env_floor;
  // tick state
  logic [19:0] env_acc;
  logic [11:0] peak, effort, knob_lvl;
  logic [4:0]  atk_shift;
  logic        gate_last;
  logic [47:0] pending[$];
  int          errors;

  function void reset_state();
    threshold = 12'd64; atk_fast = 5'd2; atk_slow = 5'd10;
    rel_min = 5'd6; rel_max = 5'd12; rel_trim = 5'd8; rel_floor = 5'd3;
    env_floor = 12'd1;
    env_acc = '0; peak = '0; effort = '0; knob_lvl = '0;
    atk_shift = atk_fast; gate_last = 1'b0;
    pending.delete();
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [11:0] val);
    case (idx)
      beg_pkg::RegThreshold: threshold = val;
      beg_pkg::RegAtkFast:   atk_fast  = val[4:0];
      beg_pkg::RegAtkSlow:   atk_slow  = val[4:0];
      beg_pkg::RegRelMin:    rel_min   = val[4:0];
      beg_pkg::RegRelMax:    rel_max   = val[4:0];
      beg_pkg::RegRelTrim:   rel_trim  = val[4:0];
      beg_pkg::RegRelFloor:  rel_floor = val[4:0];
      default:               env_floor = val;
    endcase
  endfunction

  // base + floor((to - base) * x / 4096), wrapped to five bits
  function logic [4:0] blend_shift(int base, int to, int x);
    int p, q;
    p = (to - base) * x;
    q = (p >= 0) ? (p >>> 12) : -((-p + 4095) >>> 12);
    return 5'(base + q);
  endfunction

  function void shape_knob(logic [11:0] knob, logic signed [12:0] cv);
    int v;
    longint n, inner, sm, pk;
    v = int'(knob) + int'(cv);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    knob_lvl = 12'(v);
    if (v < int'(threshold)) begin
      peak = '0; effort = '0;
      return;
    end
    if (threshold == 12'd4095) n = 4095;
    else n = (longint'(v - int'(threshold)) << 12) / (4095 - int'(threshold));
    if (n > 4095) n = 4095;
    effort = 12'(n);
    inner = (n * (3 * 4096 - 2 * n)) >> 12;
    sm = (n * inner) >> 12;
    if (sm > 4095) sm = 4095;
    pk = sm + ((sm * (4096 - sm)) >> 12);
    if (pk > 4095) pk = 4095;
    peak = 12'(pk);
  endfunction

  function void step_envelope();
    longint acc, target, stp, trim, rel;
    acc = env_acc;
    target = longint'(peak) << 8;
    if (gate_last) begin
      if (acc < target) begin
        stp = (target - acc) >> atk_shift;
        if (stp == 0) stp = 1;
        acc += stp;
        if (acc > target) acc = target;
      end else if (acc > target) begin
        stp = (acc - target) >> atk_shift;
        if (stp == 0) stp = 1;
        acc -= stp;
        if (acc < target) acc = target;
      end
    end else if (acc > 0) begin
      trim = (longint'(rel_trim) * (4096 - longint'(knob_lvl))) >> 12;
      rel = blend_shift(rel_min, rel_max, peak);
      rel = (rel > trim + rel_floor) ? rel - trim : rel_floor;
      stp = acc >> (rel & 31);
      if (stp == 0) stp = 1;
      acc -= stp;
      if (acc < (longint'(env_floor) << 8)) acc = 0;
    end
    env_acc = 20'(acc);
  endfunction

  // Note an accepted tick and queue the word it should produce.
  function void note_tick(logic [39:0] word);
    logic struck;
    shape_knob(word[11:0], word[24:12]);
    atk_shift = blend_shift(atk_fast, atk_slow, word[36:25]);
    struck = word[37] && !gate_last;
    gate_last = word[37];
    step_envelope();
    pending.push_back({3'b0, struck, effort, peak, env_acc});
  endfunction

  function void check_word(logic [47:0] got);
    logic [47:0] exp_w;
    if (pending.size() == 0) begin
      $display("%0t: unexpected word %h", $time, got);
      errors++;
      return;
    end
    exp_w = pending.pop_front();
    if (got[19:0] !== exp_w[19:0])
      $display("%0t: envelope exp %0d got %0d", $time, exp_w[19:0], got[19:0]);
    if (got[31:20] !== exp_w[31:20])
      $display("%0t: peak exp %0d got %0d", $time, exp_w[31:20], got[31:20]);
    if (got[43:32] !== exp_w[43:32])
      $display("%0t: effort exp %0d got %0d", $time, exp_w[43:32], got[43:32]);
    if (got[44] !== exp_w[44])
      $display("%0t: struck exp %0b got %0b", $time, exp_w[44], got[44]);
    if (got[44:0] !== exp_w[44:0]) errors++;
  endfunction
endclass

module tb_top;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [11:0] main_knob, [24:12] cv_offset, [36:25] attack_knob, [37] gate_on
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [19:0] envelope_level, [31:20] peak_level, [43:32] effort_level,
  // [44] note_struck
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [11:0] cfg_data_i = '0;

  int send_idle_pct, recv_stall_pct;
  envelope_scoreboard envelope_model;

  breath_envelope_generator_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sink: sample at the rising edge, then redraw tready at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) envelope_model.check_word(m_axis_tdata);
  end
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one tick word, with a random idle gap before it. The word stays
  // on the bus after acceptance until the next falling edge drives again.
  task automatic send_tick(logic [11:0] knob, logic [12:0] cv, logic [11:0] atk,
                           logic gate);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b0, gate, atk, cv, knob};
    do @(posedge clk_i); while (!s_axis_tready);
    envelope_model.note_tick({2'b0, gate, atk, cv, knob});
  endtask

  // Drop valid, hold until every expected word is back, then let the
  // sequencer settle.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (envelope_model.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [11:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    envelope_model.write_reg(idx, val);
  endtask

  task automatic end_cfg();
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly gate phrases: hold the gate for a while, then release it.
  task automatic random_ticks(int count);
    int  left;
    bit  gate;
    left = 0;
    gate = 0;
    repeat (count) begin
      if (left == 0) begin
        gate = ~gate;
        left = $urandom_range(1, 12) * ($urandom_range(3) == 0 ? 4 : 1);
      end
      left--;
      if ($urandom_range(9) == 0)
        send_tick(12'($urandom), 13'($urandom), 12'($urandom), 1'($urandom));
      else
        send_tick(12'($urandom_range(4095)), 13'($urandom_range(8190) - 4095),
                  12'($urandom), gate);
    end
  endtask

  initial begin
    #4_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    envelope_model = new();
    envelope_model.reset_state();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, strike, release, floor snap.
    send_tick(12'd0, 13'h1001, 12'd0, 1'b0);
    send_tick(12'd4095, 13'd4095, 12'd4095, 1'b1);
    send_tick(12'd4095, 13'd0, 12'd0, 1'b1);
    send_tick(12'd4095, 13'h1001, 12'd2048, 1'b1);
    send_tick(12'd2048, 13'd0, 12'd4095, 1'b1);
    send_tick(12'd63, 13'd0, 12'd0, 1'b1);
    send_tick(12'd64, 13'd0, 12'd0, 1'b0);
    send_tick(12'd4095, 13'd0, 12'd0, 1'b0);
    send_tick(12'd100, 13'h1FFF, 12'd1, 1'b1);
    send_tick(12'd3000, 13'd0, 12'hAAA, 1'b1);
    repeat (6) send_tick(12'd0, 13'd0, 12'h555, 1'b0);
    drain();

    // Threshold at full scale, slow below fast, release min above max.
    write_cfg(beg_pkg::RegThreshold, 12'd4095);
    write_cfg(beg_pkg::RegAtkFast, 12'd24);
    write_cfg(beg_pkg::RegAtkSlow, 12'd0);
    write_cfg(beg_pkg::RegRelMin, 12'd24);
    write_cfg(beg_pkg::RegRelMax, 12'd0);
    write_cfg(beg_pkg::RegRelTrim, 12'd24);
    write_cfg(beg_pkg::RegRelFloor, 12'd0);
    write_cfg(beg_pkg::RegEnvFloor, 12'd4095);
    end_cfg();
    send_tick(12'd4095, 13'd0, 12'd4095, 1'b1);
    send_tick(12'd4095, 13'd100, 12'd1000, 1'b1);
    send_tick(12'd4000, 13'd0, 12'd0, 1'b0);
    send_tick(12'd4095, 13'd0, 12'd0, 1'b1);
    send_tick(12'd0, 13'd0, 12'd0, 1'b0);
    drain();

    // Random phases over several settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      write_cfg(beg_pkg::RegThreshold, ph == 0 ? 12'd0 : 12'($urandom_range(4000)));
      write_cfg(beg_pkg::RegAtkFast, 12'($urandom_range(24)));
      write_cfg(beg_pkg::RegAtkSlow, 12'($urandom_range(24)));
      write_cfg(beg_pkg::RegRelMin, 12'($urandom_range(24)));
      write_cfg(beg_pkg::RegRelMax, 12'($urandom_range(24)));
      write_cfg(beg_pkg::RegRelTrim, 12'($urandom_range(24)));
      write_cfg(beg_pkg::RegRelFloor, 12'($urandom_range(24)));
      write_cfg(beg_pkg::RegEnvFloor, ph == 1 ? 12'd0 : 12'($urandom_range(40)));
      end_cfg();
      random_ticks(155);
      drain();
    end

    if (envelope_model.errors == 0 && envelope_model.pending.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
